@@ rtl/core/hkc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hkc_pkg: shared types, constants and helpers of the key counter table
// Entry layout, command and status codes, FNV-1a constants and key trimming.
// ----------------------------------------------------------------------------
package hkc_pkg;

  localparam int KEY_W      = 64;
  localparam int CNT_W      = 32;
  localparam int HASH_W     = 32;
  localparam int LOAD_W     = 7;
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;
  localparam int SEL_W      = 12;
  localparam int IDX_OUT_W  = 12;
  localparam int OCC_OUT_W  = 13;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 128;

  localparam int DEPTH_DEF     = 4096;
  localparam int KEY_BYTES_DEF = 8;
  localparam int LOAD_SCALE    = 100;

  localparam logic [LOAD_W-1:0] LOAD_RESET = 7'd70;
  localparam logic [HASH_W-1:0] FNV_BASIS  = 32'd2166136261;
  localparam logic [HASH_W-1:0] FNV_PRIME  = 32'd16777619;

  // command codes (code three is unused and only reports)
  localparam logic [CMD_W-1:0] CMD_COUNT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_HIT     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NEW     = 2'd1;
  localparam logic [STAT_W-1:0] ST_REFUSED = 2'd2;
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd3;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } entry_t;

  // number of leading non-zero bytes, at most kb
  function automatic logic [3:0] key_len(input logic [KEY_W-1:0] key, input int kb);
    logic [3:0] n;
    logic       alive;
    n     = '0;
    alive = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (alive && (i < kb) && (key[KEY_W-1-8*i -: 8] != 8'h00)) begin
        n = n + 4'd1;
      end else begin
        alive = 1'b0;
      end
    end
    return n;
  endfunction

  // keep the first n bytes, zero the rest
  function automatic logic [KEY_W-1:0] key_trim(input logic [KEY_W-1:0] key,
                                                input logic [3:0] n);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) begin
        k[KEY_W-1-8*i -: 8] = key[KEY_W-1-8*i -: 8];
      end
    end
    return k;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/hkc_fnv.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hkc_fnv: byte-serial FNV-1a 32-bit hash
// One key byte per cycle from the most significant end; done when bytes run out.
// ----------------------------------------------------------------------------
module hkc_fnv
  import hkc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [KEY_W-1:0]  key,
  input  wire logic [3:0]        len,
  output logic                   done,
  output logic [HASH_W-1:0]      hash
);

  logic              busy_r;
  logic [3:0]        left_r;
  logic [KEY_W-1:0]  sh_r;
  logic [HASH_W-1:0] h_r;
  logic [HASH_W-1:0] h_nxt;

  always_comb begin
    h_nxt = (h_r ^ {{(HASH_W-8){1'b0}}, sh_r[KEY_W-1 -: 8]}) * FNV_PRIME;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      left_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      left_r <= len;
    end else if (busy_r) begin
      if (left_r == 4'd0) begin
        busy_r <= 1'b0;
      end else begin
        left_r <= left_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      h_r  <= FNV_BASIS;
      sh_r <= key;
    end else if (busy_r && (left_r != 4'd0)) begin
      h_r  <= h_nxt;
      sh_r <= {sh_r[KEY_W-9:0], 8'h00};
    end
  end

  assign done = busy_r && (left_r == 4'd0);
  assign hash = h_r;

endmodule
`default_nettype wire

@@ rtl/core/hkc_mod.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hkc_mod: reduction of a 32-bit value modulo the table depth
// Mask for a power-of-two depth, otherwise a restoring remainder, one bit a cycle.
// ----------------------------------------------------------------------------
module hkc_mod
  import hkc_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEF
)
(
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [HASH_W-1:0]              value,
  output logic                                done,
  output logic [$clog2(TABLE_DEPTH)-1:0]      rem
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int STEPS = HASH_W;
  localparam int CW    = $clog2(STEPS + 1);

  if ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0) begin : g_pow2
    logic          done_r;
    logic [AW-1:0] rem_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        done_r <= 1'b0;
      end else begin
        done_r <= start;
      end
      if (start) begin
        rem_r <= value[AW-1:0];
      end
    end

    assign done = done_r;
    assign rem  = rem_r;
  end else begin : g_div
    localparam logic [AW:0] DEPTH_V = (AW+1)'(TABLE_DEPTH);

    logic              busy_r;
    logic [CW-1:0]     cnt_r;
    logic [HASH_W-1:0] val_r;
    logic [AW-1:0]     rem_r;
    logic [AW:0]       trial;
    logic [AW:0]       diff;

    // remainder stays below depth, so one trial subtract per bit suffices
    always_comb begin
      trial = {rem_r, val_r[HASH_W-1]};
      diff  = trial - DEPTH_V;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        busy_r <= 1'b0;
        cnt_r  <= '0;
      end else if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CW'(STEPS)) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (start) begin
        val_r <= value;
        rem_r <= '0;
      end else if (busy_r && (cnt_r != CW'(STEPS))) begin
        val_r <= {val_r[HASH_W-2:0], 1'b0};
        rem_r <= (trial >= DEPTH_V) ? diff[AW-1:0] : trial[AW-1:0];
      end
    end

    assign done = busy_r && (cnt_r == CW'(STEPS));
    assign rem  = rem_r;
  end

endmodule
`default_nettype wire

@@ rtl/core/hkc_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hkc_mem: slot memory
// One write and one read port, read data registered.
// ----------------------------------------------------------------------------
module hkc_mem
  import hkc_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEF
)
(
  input  wire logic                          clk,
  input  wire logic                          re,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] raddr,
  input  wire logic                          we,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] waddr,
  input  wire entry_t                        wdata,
  output entry_t                             rdata
);

  entry_t mem_r [TABLE_DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/core/hash_key_counter_linear_probe.sv @@
`default_nettype none
// Count: hash over the key bytes, modulo depth, then a probe of the slots; a non-pow-2
// depth uses the bit-serial modulo. Read: slot_select modulo depth, then a slot read.
// One item at a time; the next is taken once the result sits in the output register.
// The probe loop checks one slot per cycle through the single read port of the memory.
// Reset and the clear command sweep the table, one slot a cycle, during which no item is
// accepted; configuration writes are always taken.
// ----------------------------------------------------------------------------
// hash_key_counter_linear_probe: key counting table with linear probing
// FNV-1a hash, modulo depth, probe-and-update of a slot memory, load limit.
// ----------------------------------------------------------------------------
module hash_key_counter_linear_probe
  import hkc_pkg::*;
#(
  parameter int TABLE_DEPTH = DEPTH_DEF,
  parameter int KEY_BYTES   = KEY_BYTES_DEF
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // key[63:0], slot_select[75:64], zero pad
  input  wire logic [CMD_W-1:0]      in_tuser,   // command[1:0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // slot_index[11:0], hit_count[43:12],
                                                 // slot_valid[44], key_out[108:45],
                                                 // occupied[121:109], zero pad
  output logic [STAT_W-1:0]          out_tuser,  // status[1:0]
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [LOAD_W-1:0]     cfg_data
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int OCC_W = $clog2(TABLE_DEPTH + 1);
  localparam int PW    = OCC_W + LOAD_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_MOD, S_PROBE, S_READ, S_DONE
  } state_t;

  // registers
  state_t            state_r, state_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [LOAD_W-1:0] load_r;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic              clr_report_r, clr_report_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [AW-1:0]     probes_r, probes_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [AW-1:0]     res_idx_r, res_idx_nxt;
  logic [CNT_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic              res_valid_r, res_valid_nxt;
  logic [KEY_W-1:0]  res_key_r, res_key_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;
  logic [STAT_W-1:0] out_status_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_slot_valid_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [OCC_OUT_W-1:0] out_occ_r;

  // datapath
  logic              in_fire;
  logic [KEY_W-1:0]  in_key;
  logic [SEL_W-1:0]  in_sel;
  logic [3:0]        in_len;
  logic              over_load;
  logic              fnv_start, fnv_done;
  logic [HASH_W-1:0] fnv_hash;
  logic              mod_start, mod_done;
  logic [HASH_W-1:0] mod_value;
  logic [AW-1:0]     mod_rem;
  logic              mem_re, mem_we;
  logic [AW-1:0]     mem_raddr, mem_waddr;
  entry_t            mem_wdata, mem_rdata;
  logic [AW-1:0]     pos_inc;
  logic [31:0]       idx_wide;
  logic [31:0]       occ_wide;

  assign in_key    = in_tdata[KEY_W-1:0];
  assign in_sel    = in_tdata[KEY_W+SEL_W-1:KEY_W];
  assign in_len    = key_len(in_key, KEY_BYTES);
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign over_load = (PW'(occ_r) * PW'(LOAD_SCALE)) > (PW'(TABLE_DEPTH) * PW'(load_r));

  assign fnv_start = in_fire && (in_tuser == CMD_COUNT) && !over_load;
  assign mod_start = (state_r == S_HASH && fnv_done) || (in_fire && in_tuser == CMD_READ);
  assign mod_value = (state_r == S_HASH) ? fnv_hash : HASH_W'(in_sel);
  assign pos_inc   = (pos_r == LAST_SLOT) ? '0 : pos_r + 1'b1;

  hkc_fnv u_fnv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fnv_start),
    .key   (key_trim(in_key, in_len)),
    .len   (in_len),
    .done  (fnv_done),
    .hash  (fnv_hash)
  );

  hkc_mod #(.TABLE_DEPTH(TABLE_DEPTH)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .value (mod_value),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  hkc_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    clr_addr_nxt   = clr_addr_r;
    clr_report_nxt = clr_report_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    pos_nxt        = pos_r;
    probes_nxt     = probes_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_cnt_nxt    = res_cnt_r;
    res_valid_nxt  = res_valid_r;
    res_key_nxt    = res_key_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_load       = 1'b0;
    mem_re         = 1'b0;
    mem_raddr      = pos_r;
    mem_we         = 1'b0;
    mem_waddr      = pos_r;
    mem_wdata      = '0;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_SLOT) begin
          clr_addr_nxt   = '0;
          occ_nxt        = '0;
          clr_report_nxt = 1'b0;
          res_status_nxt = ST_DONE;
          res_idx_nxt    = '0;
          res_cnt_nxt    = '0;
          res_valid_nxt  = 1'b0;
          res_key_nxt    = '0;
          state_nxt      = clr_report_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt        = in_tuser;
          key_nxt        = key_trim(in_key, in_len);
          res_status_nxt = ST_DONE;
          res_idx_nxt    = '0;
          res_cnt_nxt    = '0;
          res_valid_nxt  = 1'b0;
          res_key_nxt    = '0;
          case (in_tuser)
            CMD_COUNT: begin
              if (over_load) begin
                res_status_nxt = ST_REFUSED;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_HASH;
              end
            end
            CMD_READ: begin
              state_nxt = S_MOD;
            end
            CMD_CLEAR: begin
              clr_addr_nxt   = '0;
              clr_report_nxt = 1'b1;
              state_nxt      = S_CLEAR;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_HASH: begin
        if (fnv_done) begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          mem_re     = 1'b1;
          mem_raddr  = mod_rem;
          pos_nxt    = mod_rem;
          probes_nxt = '0;
          state_nxt  = (cmd_r == CMD_COUNT) ? S_PROBE : S_READ;
        end
      end
      S_PROBE: begin
        // read data belongs to pos_r; the next slot is fetched while this one is checked
        if (!mem_rdata.used) begin
          mem_we          = 1'b1;
          mem_wdata.used  = 1'b1;
          mem_wdata.key   = key_r;
          mem_wdata.count = CNT_W'(1);
          occ_nxt         = occ_r + 1'b1;
          res_status_nxt  = ST_NEW;
          res_idx_nxt     = pos_r;
          res_cnt_nxt     = CNT_W'(1);
          res_valid_nxt   = 1'b1;
          res_key_nxt     = key_r;
          state_nxt       = S_DONE;
        end else if (mem_rdata.key == key_r) begin
          mem_we          = 1'b1;
          mem_wdata       = mem_rdata;
          if (mem_rdata.count != '1) begin
            mem_wdata.count = mem_rdata.count + 1'b1;
          end
          res_status_nxt  = ST_HIT;
          res_idx_nxt     = pos_r;
          res_cnt_nxt     = mem_wdata.count;
          res_valid_nxt   = 1'b1;
          res_key_nxt     = key_r;
          state_nxt       = S_DONE;
        end else if (probes_r == LAST_SLOT) begin
          // every slot visited: table full
          res_status_nxt = ST_REFUSED;
          state_nxt      = S_DONE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = pos_inc;
          pos_nxt    = pos_inc;
          probes_nxt = probes_r + 1'b1;
        end
      end
      S_READ: begin
        res_status_nxt = ST_DONE;
        res_idx_nxt    = pos_r;
        res_valid_nxt  = mem_rdata.used;
        res_cnt_nxt    = mem_rdata.used ? mem_rdata.count : '0;
        res_key_nxt    = mem_rdata.used ? mem_rdata.key : '0;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign idx_wide = 32'(res_idx_r);
  assign occ_wide = 32'(occ_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      occ_r        <= '0;
      load_r       <= LOAD_RESET;
      clr_addr_r   <= '0;
      clr_report_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      clr_addr_r   <= clr_addr_nxt;
      clr_report_r <= clr_report_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        load_r <= cfg_data;
      end
    end
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    pos_r        <= pos_nxt;
    probes_r     <= probes_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_cnt_r    <= res_cnt_nxt;
    res_valid_r  <= res_valid_nxt;
    res_key_r    <= res_key_nxt;
    if (out_load) begin
      out_status_r     <= res_status_r;
      out_idx_r        <= idx_wide[IDX_OUT_W-1:0];
      out_cnt_r        <= res_cnt_r;
      out_slot_valid_r <= res_valid_r;
      out_key_r        <= res_key_r;
      out_occ_r        <= occ_wide[OCC_OUT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_DATA_W-OCC_OUT_W-KEY_W-1-CNT_W-IDX_OUT_W){1'b0}},
                       out_occ_r, out_key_r, out_slot_valid_r, out_cnt_r, out_idx_r};

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(TABLE_DEPTH))
    else $error("occupancy exceeds table depth");

  a_new_entry_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE && !mem_rdata.used) |=> occ_r == OCC_W'($past(occ_r) + 1'b1))
    else $error("claimed slot did not raise occupancy");

  a_fnv_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    fnv_done |-> state_r == S_HASH)
    else $error("hash finished outside hashing state");

  a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> state_r == S_MOD)
    else $error("modulo finished outside its state");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re && (mem_waddr == mem_raddr)))
    else $error("read and write of the same slot in one cycle");
`endif

endmodule
`default_nettype wire

@@ tb/hash_key_counter_linear_probe_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_key_counter_linear_probe_tb: self-checking bench of the key counting table
// Drives count, read, clear and unused commands with random gaps and stalls,
// tracks the slot table in a scoreboard and checks every result field.
// ----------------------------------------------------------------------------
module hash_key_counter_linear_probe_tb;
  import hkc_pkg::*;

  localparam int DEPTH         = DEPTH_DEF;
  localparam int GAP_MAX       = 14;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 145;
  localparam int POOL_KEYS     = 40;
  localparam int SETTLE_CYCLES = 200;
  localparam int REPORT_MAX    = 10;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [IDX_OUT_W-1:0] slot_index;
    logic [CNT_W-1:0]     hit_count;
    logic                 slot_valid;
    logic [KEY_W-1:0]     key_out;
    logic [OCC_OUT_W-1:0] occupied;
  } slot_report_t;

  // mirror of the slot table plus the queue of results still owed by the block
  class key_table_tracker;
    logic [KEY_W-1:0]  slot_key [DEPTH];
    logic [CNT_W-1:0]  slot_cnt [DEPTH];
    bit                slot_used [DEPTH];
    bit                claimed_once [DEPTH];
    int                claimed_slots [$];
    int unsigned       occupancy;
    logic [LOAD_W-1:0] load_pct;
    slot_report_t      awaited [$];
    int                errors;

    function new();
      wipe();
      load_pct = LOAD_RESET;
      errors   = 0;
    endfunction

    function void wipe();
      for (int i = 0; i < DEPTH; i++) begin
        slot_used[i] = 1'b0;
        slot_key[i]  = '0;
        slot_cnt[i]  = '0;
      end
      occupancy = 0;
    endfunction

    function void set_load(input logic [LOAD_W-1:0] pct);
      load_pct = pct;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // effective key bytes (up to the first zero byte) and their fnv-1a hash
    function void fold_key(input logic [KEY_W-1:0] raw, output logic [KEY_W-1:0] eff,
                           output logic [HASH_W-1:0] h);
      logic       alive;
      logic [7:0] b;
      eff   = '0;
      h     = FNV_BASIS;
      alive = 1'b1;
      for (int i = 0; i < KEY_BYTES_DEF; i++) begin
        b = raw[KEY_W-1-8*i -: 8];
        if (b == 8'h00) alive = 1'b0;
        if (alive) begin
          eff[KEY_W-1-8*i -: 8] = b;
          h = (h ^ {24'h0, b}) * FNV_PRIME;
        end
      end
    endfunction

    function slot_report_t count_key(input logic [KEY_W-1:0] raw);
      slot_report_t      r;
      logic [KEY_W-1:0]  eff;
      logic [HASH_W-1:0] h;
      int                pos;
      bit                done;
      r        = '0;
      r.status = ST_REFUSED;
      fold_key(raw, eff, h);
      if (longint'(occupancy) * 100 > longint'(DEPTH) * longint'(load_pct)) return r;
      pos  = int'(h % DEPTH);
      done = 1'b0;
      for (int n = 0; n < DEPTH && !done; n++) begin
        if (!slot_used[pos]) begin
          slot_used[pos] = 1'b1;
          slot_key[pos]  = eff;
          slot_cnt[pos]  = 1;
          occupancy++;
          if (!claimed_once[pos]) begin
            claimed_once[pos] = 1'b1;
            claimed_slots.push_back(pos);
          end
          r.status = ST_NEW;
          done     = 1'b1;
        end else if (slot_key[pos] == eff) begin
          if (slot_cnt[pos] != '1) slot_cnt[pos]++;
          r.status = ST_HIT;
          done     = 1'b1;
        end else begin
          pos = (pos + 1) % DEPTH;
        end
      end
      if (done) begin
        r.slot_index = pos[IDX_OUT_W-1:0];
        r.hit_count  = slot_cnt[pos];
        r.slot_valid = 1'b1;
        r.key_out    = eff;
      end
      return r;
    endfunction

    function void note_command(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                               input logic [SEL_W-1:0] sel);
      slot_report_t r;
      int           pos;
      r        = '0;
      r.status = ST_DONE;
      case (cmd)
        CMD_COUNT: r = count_key(key);
        CMD_READ: begin
          pos          = int'(sel) % DEPTH;
          r.slot_index = pos[IDX_OUT_W-1:0];
          if (slot_used[pos]) begin
            r.hit_count  = slot_cnt[pos];
            r.slot_valid = 1'b1;
            r.key_out    = slot_key[pos];
          end
        end
        CMD_CLEAR: wipe();
        default: ;
      endcase
      r.occupied = occupancy[OCC_OUT_W-1:0];
      awaited.push_back(r);
    endfunction

    function void check_result(input slot_report_t got);
      slot_report_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected result at %0t: status %0d slot %0d", $time,
                   got.status, got.slot_index);
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.slot_index !== want.slot_index ||
          got.hit_count !== want.hit_count || got.slot_valid !== want.slot_valid ||
          got.key_out !== want.key_out || got.occupied !== want.occupied) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display({"mismatch at %0t (expected/actual): status %0d/%0d slot %0d/%0d ",
                    "count %0d/%0d valid %0b/%0b key %h/%h occupied %0d/%0d"}, $time,
                   want.status, got.status, want.slot_index, got.slot_index,
                   want.hit_count, got.hit_count, want.slot_valid, got.slot_valid,
                   want.key_out, got.key_out, want.occupied, got.occupied);
      end
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [CMD_W-1:0]      in_tuser   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [LOAD_W-1:0]     cfg_data   = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;
  logic                  cfg_ready;

  bit send_gaps_on   = 1'b1;
  bit take_stalls_on = 1'b1;

  key_table_tracker tracker;

  always #5 clk = ~clk;

  hash_key_counter_linear_probe u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // random key of random length, bytes after the terminating zero left as garbage
  function automatic logic [KEY_W-1:0] make_key();
    logic [KEY_W-1:0] k;
    int               len;
    k   = {$urandom, $urandom};
    len = $urandom_range(8, 0);
    for (int j = 0; j < 8; j++) begin
      if (j < len && k[KEY_W-1-8*j -: 8] == 8'h00)
        k[KEY_W-1-8*j -: 8] = 8'($urandom_range(255, 1));
      else if (j == len)
        k[KEY_W-1-8*j -: 8] = 8'h00;
    end
    return k;
  endfunction

  // same effective key, fresh bytes behind the terminator
  function automatic logic [KEY_W-1:0] reshuffle_tail(input logic [KEY_W-1:0] k);
    bit ended;
    ended = 1'b0;
    for (int j = 0; j < 8; j++) begin
      if (ended) k[KEY_W-1-8*j -: 8] = 8'($urandom);
      else if (k[KEY_W-1-8*j -: 8] == 8'h00) ended = 1'b1;
    end
    return k;
  endfunction

  // distinct full-length keys for filling the table
  function automatic logic [KEY_W-1:0] fill_key(input int i);
    logic [KEY_W-1:0] k;
    for (int j = 0; j < 8; j++) k[KEY_W-1-8*j -: 8] = 8'h80 | 8'((i >> (7 * j)) & 'h7f);
    return k;
  endfunction

  // returns at the transfer edge with tvalid still high, so a back-to-back item keeps it up
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                              input logic [SEL_W-1:0] sel);
    int gap;
    gap = send_gaps_on ? $urandom_range(GAP_MAX, 0) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_DATA_W-KEY_W-SEL_W){1'b0}}, sel, key};
    do @(posedge clk); while (!in_tready);
    tracker.note_command(cmd, key, sel);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_load(input logic [LOAD_W-1:0] pct);
    cfg_valid <= 1'b1;
    cfg_data  <= pct;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_load(pct);
  endtask

  function automatic logic [SEL_W-1:0] any_slot();
    return SEL_W'($urandom);
  endfunction

  function automatic logic [SEL_W-1:0] known_slot();
    return SEL_W'(tracker.claimed_slots[$urandom_range(tracker.claimed_slots.size() - 1, 0)]);
  endfunction

  // result side
  initial begin
    int           stall;
    slot_report_t got;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = take_stalls_on ? $urandom_range(GAP_MAX, 0) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.status     = out_tuser;
      got.slot_index = out_tdata[11:0];
      got.hit_count  = out_tdata[43:12];
      got.slot_valid = out_tdata[44];
      got.key_out    = out_tdata[108:45];
      got.occupied   = out_tdata[121:109];
      tracker.check_result(got);
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL hash_key_counter_linear_probe");
    $finish;
  end

  initial begin
    logic [KEY_W-1:0]  pool [$];
    logic [LOAD_W-1:0] phase_loads [PHASES];
    int                r;
    phase_loads = '{7'd1, 7'd100, 7'd5, 7'd127, 7'd70, 7'd2, 7'd50, 7'd1};
    tracker = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty key, key equality past the terminator, full-width keys
    send_command(CMD_COUNT, 64'h0000_0000_0000_0000, any_slot());
    send_command(CMD_COUNT, 64'h00FF_FFFF_FFFF_FFFF, any_slot());
    send_command(CMD_COUNT, 64'hFFFF_FFFF_FFFF_FFFF, any_slot());
    send_command(CMD_COUNT, 64'hFFFF_FFFF_FFFF_FFFF, any_slot());
    send_command(CMD_COUNT, 64'h4142_4300_5555_5555, any_slot());
    send_command(CMD_COUNT, 64'h4142_4300_AAAA_AAAA, any_slot());
    send_command(CMD_COUNT, 64'h0102_0304_0506_0708, any_slot());
    send_command(CMD_COUNT, 64'h8000_0000_0000_0001, any_slot());
    send_command(CMD_READ, {$urandom, $urandom}, SEL_W'(tracker.claimed_slots[0]));
    send_command(CMD_READ, {$urandom, $urandom}, SEL_W'(tracker.claimed_slots[1]));
    send_command(CMD_READ, {$urandom, $urandom}, SEL_W'(tracker.claimed_slots[2]));
    send_command(CMD_UNUSED, {$urandom, $urandom}, any_slot());
    send_command(CMD_CLEAR, {$urandom, $urandom}, any_slot());
    // slot was written before the clear, now empty
    send_command(CMD_READ, {$urandom, $urandom}, SEL_W'(tracker.claimed_slots[1]));
    send_command(CMD_COUNT, 64'hFFFF_FFFF_FFFF_FFFF, any_slot());
    settle();

    // zero load: first entry still goes in, everything after is refused
    write_load(7'd0);
    send_command(CMD_CLEAR, {$urandom, $urandom}, any_slot());
    send_command(CMD_COUNT, 64'h4142_4300_0000_0000, any_slot());
    send_command(CMD_COUNT, 64'h4142_4300_1234_5678, any_slot());
    send_command(CMD_COUNT, 64'h0000_0000_0000_0001, any_slot());

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_load(phase_loads[ph]);
      send_gaps_on   = (ph % 3 != 2);
      take_stalls_on = (ph % 4 != 1);
      send_command(CMD_CLEAR, {$urandom, $urandom}, any_slot());
      pool.delete();
      repeat (POOL_KEYS) pool.push_back(make_key());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99, 0);
        if (r < 66) begin
          if ($urandom_range(2, 0) == 0)
            send_command(CMD_COUNT, make_key(), any_slot());
          else
            send_command(CMD_COUNT, reshuffle_tail(pool[$urandom_range(POOL_KEYS - 1, 0)]),
                         any_slot());
        end else if (r < 88 && tracker.claimed_slots.size() != 0) begin
          send_command(CMD_READ, {$urandom, $urandom}, known_slot());
        end else if (r < 94) begin
          send_command(CMD_COUNT, {$urandom, $urandom}, any_slot());
        end else if (r < 99) begin
          send_command(CMD_UNUSED, {$urandom, $urandom}, any_slot());
        end else begin
          send_command(CMD_CLEAR, {$urandom, $urandom}, any_slot());
        end
      end
    end

    // fill every slot, then a full table refuses a new key but still counts an old one
    settle();
    write_load(7'd100);
    send_gaps_on   = 1'b0;
    take_stalls_on = 1'b0;
    send_command(CMD_CLEAR, {$urandom, $urandom}, any_slot());
    for (int i = 0; i < DEPTH; i++) send_command(CMD_COUNT, fill_key(i), any_slot());
    send_command(CMD_COUNT, fill_key(DEPTH), any_slot());
    send_command(CMD_COUNT, fill_key(7), any_slot());
    send_command(CMD_READ, {$urandom, $urandom}, '0);
    send_command(CMD_READ, {$urandom, $urandom}, '1);
    settle();
    write_load(7'd127);
    send_gaps_on   = 1'b1;
    take_stalls_on = 1'b1;
    send_command(CMD_COUNT, fill_key(DEPTH + 1), any_slot());
    send_command(CMD_CLEAR, {$urandom, $urandom}, any_slot());
    send_command(CMD_READ, {$urandom, $urandom}, '1);

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.pending() != 0) begin
      tracker.errors++;
      $display("%0d results never arrived", tracker.pending());
    end
    if (tracker.errors == 0) begin
      $display("PASS hash_key_counter_linear_probe");
    end else begin
      $display("FAIL hash_key_counter_linear_probe");
    end
    $finish;
  end

endmodule
